/* rtl/core/bilg_pkg.sv */
// Shared constants and unit request/response types for the IoU box loss block.
// No dependencies; compiled first.
`default_nettype none

package bilg_pkg;

	localparam int DIST_W     = 24;   // signed Q16.8 distance
	localparam int MAG_W      = 23;   // positive distance magnitude
	localparam int EDGE_W     = 24;   // sum of two distances
	localparam int AREA_W     = 48;
	localparam int UNION_W    = 49;
	localparam int SCALE_W    = 24;
	localparam int GRAD_W     = 32;
	localparam int LOSS_W     = 20;
	localparam int SUM_W      = 44;
	localparam int POS_W      = 24;
	localparam int MUL_W      = 32;
	localparam int PROD_W     = 64;
	localparam int MUL_DIGIT  = 4;    // multiplier bits consumed per cycle
	localparam int DIV_W      = 64;   // dividend shift register
	localparam int DIV_CNT_W  = 7;
	localparam int FRAC_BITS  = 16;
	localparam int IOU_W      = 33;   // Q1.32 ratio, 1.0 included
	localparam int MANT_W     = 31;   // Q1.30 mantissa
	localparam int LOG_ITERS  = 20;
	localparam int LOG_FRAC_W = 20;
	localparam int T2_W       = 40;

	localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd65536;
	localparam logic [IOU_W-1:0]     IOU_MIN     = 33'd43;
	localparam logic [MUL_W-1:0]     LN2_Q32     = 32'hB17217F8;
	localparam logic [PROD_W-1:0]    LN_ROUND    = 64'h0000_0008_0000_0000;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS   = 7'd64;
	localparam logic [DIV_CNT_W-1:0] IOU_STEPS   = 7'd80;

	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [UNION_W-1:0]   divisor;
		logic [DIV_CNT_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/bilg_if.sv */
// Input and output stream interfaces (valid/ready) of the IoU box loss block.
// Depends on bilg_pkg for field widths.
`default_nettype none

interface bilg_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [bilg_pkg::DIST_W-1:0] pred_top;
	logic signed [bilg_pkg::DIST_W-1:0] pred_bottom;
	logic signed [bilg_pkg::DIST_W-1:0] pred_left;
	logic signed [bilg_pkg::DIST_W-1:0] pred_right;
	logic signed [bilg_pkg::DIST_W-1:0] true_top;
	logic signed [bilg_pkg::DIST_W-1:0] true_bottom;
	logic signed [bilg_pkg::DIST_W-1:0] true_left;
	logic signed [bilg_pkg::DIST_W-1:0] true_right;
	logic                                last_pixel;

	modport source (output valid, pred_top, pred_bottom, pred_left, pred_right,
		true_top, true_bottom, true_left, true_right, last_pixel, input ready);
	modport sink (input valid, pred_top, pred_bottom, pred_left, pred_right,
		true_top, true_bottom, true_left, true_right, last_pixel, output ready);
endinterface

interface bilg_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bilg_pkg::GRAD_W-1:0] grad_top;
	logic signed [bilg_pkg::GRAD_W-1:0] grad_bottom;
	logic signed [bilg_pkg::GRAD_W-1:0] grad_left;
	logic signed [bilg_pkg::GRAD_W-1:0] grad_right;
	logic        [bilg_pkg::LOSS_W-1:0] pixel_loss;
	logic                                pixel_valid;
	logic        [bilg_pkg::LOSS_W-1:0] mean_loss;
	logic        [bilg_pkg::POS_W-1:0]  positive_total;
	logic                                batch_done;

	modport source (output valid, grad_top, grad_bottom, grad_left, grad_right,
		pixel_loss, pixel_valid, mean_loss, positive_total, batch_done, input ready);
	modport sink (input valid, grad_top, grad_bottom, grad_left, grad_right,
		pixel_loss, pixel_valid, mean_loss, positive_total, batch_done, output ready);
endinterface

`default_nettype wire

/* rtl/core/bilg_mul.sv */
// Digit-serial unsigned multiplier, 32x32 -> 64, one 4-bit digit of b per cycle.
// Depends on bilg_pkg (mul_req_t / mul_rsp_t).
`default_nettype none

module bilg_mul (
	input  logic               clk,
	input  logic               arst_n,
	input  bilg_pkg::mul_req_t req,
	output bilg_pkg::mul_rsp_t rsp
);
	localparam int STEPS = bilg_pkg::MUL_W / bilg_pkg::MUL_DIGIT;
	localparam int CNT_W = $clog2(STEPS);
	localparam int PP_W  = bilg_pkg::MUL_W + bilg_pkg::MUL_DIGIT;

	logic                          busy_q;
	logic                          done_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [bilg_pkg::MUL_W-1:0]    a_q;
	logic [bilg_pkg::MUL_W-1:0]    b_q;
	logic [bilg_pkg::PROD_W-1:0]   acc_q;
	logic [PP_W-1:0]               pp;

	// partial product of a and the top digit of b
	assign pp = PP_W'(a_q) * PP_W'(b_q[bilg_pkg::MUL_W-1 -: bilg_pkg::MUL_DIGIT]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[bilg_pkg::PROD_W-bilg_pkg::MUL_DIGIT-1:0],
				bilg_pkg::MUL_DIGIT'(0)} + bilg_pkg::PROD_W'(pp);
			b_q   <= b_q << bilg_pkg::MUL_DIGIT;
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

`default_nettype wire

/* rtl/core/bilg_div.sv */
// Bit-serial restoring divider: 64-bit dividend streamed MSB first, 49-bit divisor,
// one quotient bit per cycle for a programmable step count. Depends on bilg_pkg.
`default_nettype none

module bilg_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bilg_pkg::div_req_t req,
	output bilg_pkg::div_rsp_t rsp
);
	localparam int DW = bilg_pkg::UNION_W;

	logic                              busy_q;
	logic                              done_q;
	logic [bilg_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [bilg_pkg::DIV_W-1:0]        num_q;
	logic [DW-1:0]                     d_q;
	logic [DW-1:0]                     rem_q;
	logic [bilg_pkg::DIV_W-1:0]        quot_q;
	logic [DW:0]                       trial;
	logic [DW:0]                       diff;
	logic                              ge;

	assign trial = {rem_q, num_q[bilg_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - bilg_pkg::DIV_CNT_W'(1);
			if (cnt_q == bilg_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q  <= req.dividend;
			d_q    <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			// zeros shift in once the dividend bits are used up
			num_q  <= num_q << 1;
			rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quot_q <= {quot_q[bilg_pkg::DIV_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

/* rtl/core/box_iou_loss_gradient.sv */
// IoU box loss and gradient unit. One pixel (four predicted and four true edge distances,
// signed Q16.8) is taken per beat and gives one result beat: four saturated Q8.24
// gradients scaled by grad_scale, -ln(IoU) in Q4.16, and on the last pixel of a batch the
// mean loss and positive count, after which both totals clear. Pixels are worked one at a
// time through a shared nibble-serial multiplier and a bit-serial divider (one quotient
// bit per cycle); the divider dominates. A pixel with a valid box needs 28 products,
// one 80-step and six 64-step divisions and up to 27 normalize shifts, with a handoff
// around each operation. A skipped pixel bypasses the arithmetic and runs only the mean
// division when it closes a batch. A new pixel is accepted while the previous result
// waits in the output register.
// Depends on bilg_pkg, bilg_if, bilg_mul, bilg_div.
`default_nettype none

module box_iou_loss_gradient #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bilg_pkg::SCALE_W-1:0]    cfg_wdata,
	bilg_in_if.sink                         in_ch,
	bilg_out_if.source                      out_ch
);
	localparam int SUB_W = 5;
	localparam int MW    = bilg_pkg::MAG_W;
	localparam int EW    = bilg_pkg::EDGE_W;

	typedef enum logic [3:0] {
		S_IDLE, S_AREA, S_IOU, S_NORM, S_SQR, S_LN, S_T2, S_NUM, S_T1, S_FIN, S_MEAN, S_OUT
	} state_t;

	function automatic logic [MW-1:0] clamp_pos(input logic signed [bilg_pkg::DIST_W-1:0] x);
		return (x < 24'sd1) ? MW'(1) : x[MW-1:0];
	endfunction

	function automatic logic [bilg_pkg::GRAD_W-1:0] grad_sat(
		input logic [bilg_pkg::DIV_W-1:0] t1,
		input logic [bilg_pkg::T2_W-1:0]  t2
	);
		logic [bilg_pkg::DIV_W+1:0] d;
		d = {2'b00, t1} - (bilg_pkg::DIV_W + 2)'(t2);
		if (d[bilg_pkg::DIV_W+1:bilg_pkg::GRAD_W-1] == '0 ||
				d[bilg_pkg::DIV_W+1:bilg_pkg::GRAD_W-1] == '1) begin
			return d[bilg_pkg::GRAD_W-1:0];
		end else if (d[bilg_pkg::DIV_W+1]) begin
			return 32'h8000_0000;
		end else begin
			return 32'h7FFF_FFFF;
		end
	endfunction

	// control
	state_t                          state_q;
	logic [SUB_W-1:0]                sub_q;
	logic                            mul_go_q;
	logic                            div_go_q;
	logic                            out_valid_q;
	logic [bilg_pkg::SCALE_W-1:0]    grad_scale_q;
	logic [bilg_pkg::SUM_W-1:0]      loss_sum_q;
	logic [COUNT_WIDTH-1:0]          count_q;

	// per-pixel datapath
	logic [EW-1:0]                   ih_q, iw_q, svp_q, shp_q, sv_q, sh_q;
	logic [3:0]                      cflag_q;     // {right, left, bottom, top}
	logic                            valid_q;
	logic                            last_q;
	logic [bilg_pkg::AREA_W-1:0]     ia_q, pa_q, nprod_q;
	logic [bilg_pkg::UNION_W-1:0]    ua_q;
	logic [bilg_pkg::IOU_W-1:0]      x_q;
	logic [5:0]                      k_q;
	logic [bilg_pkg::MANT_W-1:0]     m_q;
	logic [bilg_pkg::LOG_FRAC_W-1:0] frac_q;
	logic [bilg_pkg::LOSS_W-1:0]     loss_q;
	logic [bilg_pkg::LOSS_W-1:0]     mean_q;
	logic [bilg_pkg::T2_W-1:0]       t2h_q, t2w_q;
	logic [bilg_pkg::GRAD_W-1:0]     grad_q [4];

	bilg_pkg::mul_req_t mul_req;
	bilg_pkg::mul_rsp_t mul_rsp;
	bilg_pkg::div_req_t div_req;
	bilg_pkg::div_rsp_t div_rsp;

	// accept-time decode
	logic                            in_acc;
	logic [MW-1:0]                   p_t, p_b, p_l, p_r, t_t, t_b, t_l, t_r;
	logic                            valid_in, pos_in;
	logic signed [EW:0]              sv_in, sh_in;
	logic [EW-1:0]                   ih_in, iw_in;

	// step logic
	logic [24:0]                     nl2;
	logic [bilg_pkg::PROD_W-1:0]     ln_sum;
	logic [27:0]                     ln_val;
	logic [bilg_pkg::LOSS_W-1:0]     loss_next;
	logic [bilg_pkg::IOU_W-1:0]      iou_raw;
	logic [31:0]                     sq;
	logic [EW-1:0]                   num_base, num_dim, num_val;
	logic                            cur_c;
	logic [bilg_pkg::T2_W-1:0]       t2_use;
	logic [bilg_pkg::SUM_W:0]        sum_ext;
	logic [31:0]                     count32;
	logic [bilg_pkg::POS_W-1:0]      pos_total;
	logic                            out_load;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	assign p_t = clamp_pos(in_ch.pred_top);
	assign p_b = clamp_pos(in_ch.pred_bottom);
	assign p_l = clamp_pos(in_ch.pred_left);
	assign p_r = clamp_pos(in_ch.pred_right);
	assign t_t = in_ch.true_top[MW-1:0];
	assign t_b = in_ch.true_bottom[MW-1:0];
	assign t_l = in_ch.true_left[MW-1:0];
	assign t_r = in_ch.true_right[MW-1:0];

	assign valid_in = (in_ch.true_top > 24'sd0) && (in_ch.true_bottom > 24'sd0) &&
		(in_ch.true_left > 24'sd0) && (in_ch.true_right > 24'sd0);
	assign sv_in = (EW + 1)'(in_ch.true_top) + (EW + 1)'(in_ch.true_bottom);
	assign sh_in = (EW + 1)'(in_ch.true_left) + (EW + 1)'(in_ch.true_right);
	// looser positive rule: both extents nonzero with the same sign, top positive
	assign pos_in = (sv_in != '0) && (sh_in != '0) && (sv_in[EW] == sh_in[EW]) &&
		(in_ch.true_top > 24'sd0);

	assign ih_in = EW'((p_t < t_t) ? p_t : t_t) + EW'((p_b < t_b) ? p_b : t_b);
	assign iw_in = EW'((p_l < t_l) ? p_l : t_l) + EW'((p_r < t_r) ? p_r : t_r);

	// -log2 in Q.20, then times ln 2 in Q0.32 with rounding
	assign nl2       = {5'(6'd32 - k_q), 20'b0} - 25'(frac_q);
	assign ln_sum    = mul_rsp.prod + bilg_pkg::LN_ROUND;
	assign ln_val    = ln_sum[63:36];
	assign loss_next = (ln_val[27:20] != '0) ? '1 : ln_val[19:0];
	assign iou_raw   = div_rsp.quot[bilg_pkg::IOU_W-1:0];
	assign sq        = mul_rsp.prod[61:30];

	// gradient j = sub_q[1:0]: top/bottom use the width terms and the height t2, left/right the reverse
	assign cur_c    = cflag_q[sub_q[1:0]];
	assign num_base = sub_q[1] ? svp_q : shp_q;
	assign num_dim  = sub_q[1] ? ih_q : iw_q;
	assign num_val  = num_base - (cur_c ? num_dim : '0);
	assign t2_use   = cur_c ? (sub_q[1] ? t2w_q : t2h_q) : '0;

	assign sum_ext   = {1'b0, loss_sum_q} + (bilg_pkg::SUM_W + 1)'(loss_q);
	assign count32   = 32'(count_q);
	assign pos_total = (count32 > 32'h00FF_FFFF) ? '1 : count32[bilg_pkg::POS_W-1:0];
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ch.ready);

	// unit operand selection
	always_comb begin
		mul_req.start = mul_go_q;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			S_AREA: begin
				if (sub_q == SUB_W'(0)) begin
					mul_req.a = 32'(ih_q);
					mul_req.b = 32'(iw_q);
				end else if (sub_q == SUB_W'(1)) begin
					mul_req.a = 32'(svp_q);
					mul_req.b = 32'(shp_q);
				end else begin
					mul_req.a = 32'(sv_q);
					mul_req.b = 32'(sh_q);
				end
			end
			S_SQR: begin
				mul_req.a = 32'(m_q);
				mul_req.b = 32'(m_q);
			end
			S_LN: begin
				mul_req.a = 32'(nl2);
				mul_req.b = bilg_pkg::LN2_Q32;
			end
			S_NUM: begin
				mul_req.a = 32'(grad_scale_q);
				mul_req.b = 32'(num_val);
			end
			default: ;
		endcase
	end

	always_comb begin
		div_req.start    = div_go_q;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		div_req.steps    = bilg_pkg::DIV_STEPS;
		case (state_q)
			S_IOU: begin
				div_req.dividend = {ia_q, 16'b0};
				div_req.divisor  = ua_q;
				div_req.steps    = bilg_pkg::IOU_STEPS;
			end
			S_T2: begin
				div_req.dividend = 64'({grad_scale_q, 16'b0});
				div_req.divisor  = 49'(sub_q[0] ? iw_q : ih_q);
			end
			S_T1: begin
				div_req.dividend = {nprod_q, 16'b0};
				div_req.divisor  = ua_q;
			end
			S_MEAN: begin
				div_req.dividend = 64'(loss_sum_q);
				div_req.divisor  = (count_q == '0) ? 49'd1 : 49'(count_q);
			end
			default: ;
		endcase
	end

	bilg_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	bilg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sub_q        <= '0;
			mul_go_q     <= 1'b0;
			div_go_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			grad_scale_q <= bilg_pkg::SCALE_RESET;
			loss_sum_q   <= '0;
			count_q      <= '0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			if (cfg_we) begin
				grad_scale_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						if (pos_in && count_q != '1) begin
							count_q <= count_q + COUNT_WIDTH'(1);
						end
						if (valid_in) begin
							state_q  <= S_AREA;
							sub_q    <= '0;
							mul_go_q <= 1'b1;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_AREA: begin
					if (mul_rsp.done) begin
						if (sub_q == SUB_W'(2)) begin
							state_q  <= S_IOU;
							div_go_q <= 1'b1;
						end else begin
							sub_q    <= sub_q + SUB_W'(1);
							mul_go_q <= 1'b1;
						end
					end
				end
				S_IOU: begin
					if (div_rsp.done) begin
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					if (x_q[bilg_pkg::IOU_W-1]) begin
						state_q  <= S_SQR;
						sub_q    <= '0;
						mul_go_q <= 1'b1;
					end
				end
				S_SQR: begin
					if (mul_rsp.done) begin
						mul_go_q <= 1'b1;
						if (sub_q == SUB_W'(bilg_pkg::LOG_ITERS - 1)) begin
							state_q <= S_LN;
						end else begin
							sub_q <= sub_q + SUB_W'(1);
						end
					end
				end
				S_LN: begin
					if (mul_rsp.done) begin
						state_q  <= S_T2;
						sub_q    <= '0;
						div_go_q <= 1'b1;
					end
				end
				S_T2: begin
					if (div_rsp.done) begin
						if (sub_q == SUB_W'(1)) begin
							state_q  <= S_NUM;
							sub_q    <= '0;
							mul_go_q <= 1'b1;
						end else begin
							sub_q    <= sub_q + SUB_W'(1);
							div_go_q <= 1'b1;
						end
					end
				end
				S_NUM: begin
					if (mul_rsp.done) begin
						state_q  <= S_T1;
						div_go_q <= 1'b1;
					end
				end
				S_T1: begin
					if (div_rsp.done) begin
						if (sub_q == SUB_W'(3)) begin
							state_q <= S_FIN;
						end else begin
							sub_q    <= sub_q + SUB_W'(1);
							state_q  <= S_NUM;
							mul_go_q <= 1'b1;
						end
					end
				end
				S_FIN: begin
					if (valid_q) begin
						loss_sum_q <= sum_ext[bilg_pkg::SUM_W] ? '1 : sum_ext[bilg_pkg::SUM_W-1:0];
					end
					if (last_q) begin
						state_q  <= S_MEAN;
						div_go_q <= 1'b1;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_MEAN: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
						if (last_q) begin
							loss_sum_q <= '0;
							count_q    <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ih_q    <= ih_in;
			iw_q    <= iw_in;
			svp_q   <= EW'(p_t) + EW'(p_b);
			shp_q   <= EW'(p_l) + EW'(p_r);
			sv_q    <= EW'(t_t) + EW'(t_b);
			sh_q    <= EW'(t_l) + EW'(t_r);
			cflag_q <= {p_r < t_r, p_l < t_l, p_b < t_b, p_t < t_t};
			valid_q <= valid_in;
			last_q  <= in_ch.last_pixel;
			loss_q  <= '0;
			mean_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				grad_q[i] <= '0;
			end
		end
		case (state_q)
			S_AREA: begin
				if (mul_rsp.done) begin
					if (sub_q == SUB_W'(0)) begin
						ia_q <= mul_rsp.prod[bilg_pkg::AREA_W-1:0];
					end else if (sub_q == SUB_W'(1)) begin
						pa_q <= mul_rsp.prod[bilg_pkg::AREA_W-1:0];
					end else begin
						ua_q <= bilg_pkg::UNION_W'(pa_q) +
							bilg_pkg::UNION_W'(mul_rsp.prod[bilg_pkg::AREA_W-1:0]) -
							bilg_pkg::UNION_W'(ia_q);
					end
				end
			end
			S_IOU: begin
				if (div_rsp.done) begin
					x_q <= (iou_raw < bilg_pkg::IOU_MIN) ? bilg_pkg::IOU_MIN : iou_raw;
					k_q <= 6'd32;
				end
			end
			S_NORM: begin
				// shift until the ratio's top bit reaches bit 32
				if (!x_q[bilg_pkg::IOU_W-1]) begin
					x_q <= x_q << 1;
					k_q <= k_q - 6'd1;
				end else begin
					m_q    <= x_q[bilg_pkg::IOU_W-1:2];
					frac_q <= '0;
				end
			end
			S_SQR: begin
				if (mul_rsp.done) begin
					m_q    <= sq[31] ? sq[31:1] : sq[30:0];
					frac_q <= {frac_q[bilg_pkg::LOG_FRAC_W-2:0], sq[31]};
				end
			end
			S_LN: begin
				if (mul_rsp.done) begin
					loss_q <= loss_next;
				end
			end
			S_T2: begin
				if (div_rsp.done) begin
					if (sub_q[0]) begin
						t2w_q <= div_rsp.quot[bilg_pkg::T2_W-1:0];
					end else begin
						t2h_q <= div_rsp.quot[bilg_pkg::T2_W-1:0];
					end
				end
			end
			S_NUM: begin
				if (mul_rsp.done) begin
					nprod_q <= mul_rsp.prod[bilg_pkg::AREA_W-1:0];
				end
			end
			S_T1: begin
				if (div_rsp.done) begin
					grad_q[sub_q[1:0]] <= grad_sat(div_rsp.quot, t2_use);
				end
			end
			S_MEAN: begin
				if (div_rsp.done) begin
					mean_q <= (div_rsp.quot[63:20] != '0) ? '1 : div_rsp.quot[19:0];
				end
			end
			S_OUT: begin
				if (out_load) begin
					out_ch.grad_top       <= grad_q[0];
					out_ch.grad_bottom    <= grad_q[1];
					out_ch.grad_left      <= grad_q[2];
					out_ch.grad_right     <= grad_q[3];
					out_ch.pixel_loss     <= loss_q;
					out_ch.pixel_valid    <= valid_q;
					out_ch.mean_loss      <= mean_q;
					out_ch.positive_total <= last_q ? pos_total : '0;
					out_ch.batch_done     <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid = out_valid_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_go_q && div_go_q))
		else $error("multiplier and divider started together");

	a_sum_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_FIN && state_q != S_OUT) |=> $stable(loss_sum_q))
		else $error("loss sum changed outside update or report");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && state_q != S_OUT) |=> $stable(count_q))
		else $error("positive count changed without a beat");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_valid_q && state_q == S_IDLE))
		else $error("result load did not present a beat");

endmodule

`default_nettype wire

/* test/box_iou_loss_gradient_tb.sv */
// Testbench for box_iou_loss_gradient: directed and random pixels, predicted results
// checked field by field. Depends on bilg_pkg, bilg_if and the block's RTL.
`timescale 1ns / 100ps

module box_iou_loss_gradient_tb;

	localparam int IDLE_LIMIT = 40000;
	localparam logic [bilg_pkg::POS_W-1:0] CNT_MAX = {bilg_pkg::POS_W{1'b1}};
	localparam logic [bilg_pkg::SUM_W-1:0] LOSS_SUM_MAX = {bilg_pkg::SUM_W{1'b1}};

	typedef struct {
		logic signed [bilg_pkg::DIST_W-1:0] pt, pb, pl, pr, tt, tb, tl, tr;
		logic                               last;
	} pixel_t;

	typedef struct {
		logic signed [bilg_pkg::GRAD_W-1:0] gt, gb, gl, gr;
		logic [bilg_pkg::LOSS_W-1:0]        loss;
		logic                               pvalid;
		logic [bilg_pkg::LOSS_W-1:0]        mean;
		logic [bilg_pkg::POS_W-1:0]         total;
		logic                               done;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bilg_pkg::SCALE_W-1:0] cfg_wdata = '0;

	bilg_in_if  in_ch ();
	bilg_out_if out_ch ();

	box_iou_loss_gradient dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [bilg_pkg::SCALE_W-1:0] scale_q = bilg_pkg::SCALE_RESET;
	logic [bilg_pkg::SUM_W-1:0]   loss_acc = '0;
	logic [bilg_pkg::POS_W-1:0]   pos_cnt = '0;

	result_t expected_q[$];
	int  fails = 0;
	bit  no_idle = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pred_top = '0; in_ch.pred_bottom = '0;
		in_ch.pred_left = '0; in_ch.pred_right = '0;
		in_ch.true_top = '0; in_ch.true_bottom = '0;
		in_ch.true_left = '0; in_ch.true_right = '0;
		in_ch.last_pixel = 1'b0;
		out_ch.ready = 1'b0;
	end

	function automatic longint unsigned scaled_div(longint unsigned a, longint unsigned d);
		longint unsigned q, r;
		q = a / d;
		r = a % d;
		if (q > (64'd1 << 40)) q = 64'd1 << 40;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	function automatic logic [bilg_pkg::LOSS_W-1:0] neg_ln(longint unsigned r);
		int unsigned k;
		longint unsigned m, frac, nl2, v;
		k = 0;
		frac = 0;
		while (k < 63 && (r >> (k + 1)) != 0) k++;
		m = (k >= 30) ? (r >> (k - 30)) : (r << (30 - k));
		for (int i = 0; i < bilg_pkg::LOG_ITERS; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 64'd1;
			end
		end
		nl2 = (longint'(32 - k) << 20) - frac;
		v = (nl2 * 64'hB17217F8 + (64'd1 << 35)) >> 36;
		return (v > 64'hFFFFF) ? 20'hFFFFF : v[bilg_pkg::LOSS_W-1:0];
	endfunction

	function automatic logic signed [bilg_pkg::GRAD_W-1:0] sat_grad(longint unsigned t1,
			longint unsigned t2);
		longint d;
		d = longint'(t1) - longint'(t2);
		if (d > 64'sd2147483647) d = 64'sd2147483647;
		if (d < -64'sd2147483648) d = -64'sd2147483648;
		return d[bilg_pkg::GRAD_W-1:0];
	endfunction

	function automatic result_t predict_pixel(pixel_t p);
		longint pt, pb, pl, pr, tt, tb, tl, tr, sv, sh;
		longint unsigned ih, iw, svp, shp, ia, ua, r, rem, s16, c;
		bit ct, cb, cl, cr;
		result_t o;
		pt = p.pt; pb = p.pb; pl = p.pl; pr = p.pr;
		tt = p.tt; tb = p.tb; tl = p.tl; tr = p.tr;
		if (pt < 1) pt = 1;
		if (pb < 1) pb = 1;
		if (pl < 1) pl = 1;
		if (pr < 1) pr = 1;
		sv = tt + tb;
		sh = tl + tr;
		o = '{default: '0};
		if (((sv > 0 && sh > 0) || (sv < 0 && sh < 0)) && tt > 0 && pos_cnt != CNT_MAX)
			pos_cnt++;
		if (tt > 0 && tb > 0 && tl > 0 && tr > 0) begin
			ih = ((pt < tt) ? pt : tt) + ((pb < tb) ? pb : tb);
			iw = ((pl < tl) ? pl : tl) + ((pr < tr) ? pr : tr);
			svp = pt + pb;
			shp = pl + pr;
			ia = ih * iw;
			ua = svp * shp + longint'(sv) * longint'(sh) - ia;
			s16 = longint'(scale_q) << 16;
			ct = pt < tt; cb = pb < tb; cl = pl < tl; cr = pr < tr;
			r = 0;
			rem = ia;
			if (rem >= ua) begin
				rem = rem - ua;
				r = 1;
			end
			for (int i = 0; i < 32; i++) begin
				rem = rem << 1;
				r = r << 1;
				if (rem >= ua) begin
					rem = rem - ua;
					r = r | 64'd1;
				end
			end
			if (r < 43) r = 43;
			o.loss = neg_ln(r);
			o.gt = sat_grad(scaled_div(scale_q * (shp - (ct ? iw : 0)), ua), ct ? s16 / ih : 0);
			o.gb = sat_grad(scaled_div(scale_q * (shp - (cb ? iw : 0)), ua), cb ? s16 / ih : 0);
			o.gl = sat_grad(scaled_div(scale_q * (svp - (cl ? ih : 0)), ua), cl ? s16 / iw : 0);
			o.gr = sat_grad(scaled_div(scale_q * (svp - (cr ? ih : 0)), ua), cr ? s16 / iw : 0);
			o.pvalid = 1'b1;
			if (LOSS_SUM_MAX - loss_acc < o.loss) loss_acc = LOSS_SUM_MAX;
			else loss_acc = loss_acc + o.loss;
		end
		if (p.last) begin
			c = (pos_cnt != 0) ? pos_cnt : 1;
			c = loss_acc / c;
			o.mean = (c > 64'hFFFFF) ? 20'hFFFFF : c[bilg_pkg::LOSS_W-1:0];
			o.total = pos_cnt;
			o.done = 1'b1;
			loss_acc = '0;
			pos_cnt = '0;
		end
		return o;
	endfunction

	function automatic int rand_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (no_idle || sel < 60) return 0;
		if (sel < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	// Valid stays high across back-to-back beats; lowered when a gap follows or results are drained.
	task automatic send_pixel(pixel_t p);
		int gap;
		gap = rand_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pred_top <= p.pt; in_ch.pred_bottom <= p.pb;
		in_ch.pred_left <= p.pl; in_ch.pred_right <= p.pr;
		in_ch.true_top <= p.tt; in_ch.true_bottom <= p.tb;
		in_ch.true_left <= p.tl; in_ch.true_right <= p.tr;
		in_ch.last_pixel <= p.last;
		do @(posedge clk); while (!in_ch.ready);
		expected_q.push_back(predict_pixel(p));
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_scale(logic [bilg_pkg::SCALE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_q = v;
	endtask

	function automatic pixel_t mk(int pt, int pb, int pl, int pr,
			int tt, int tb, int tl, int tr, bit last);
		pixel_t p;
		p.pt = pt[bilg_pkg::DIST_W-1:0]; p.pb = pb[bilg_pkg::DIST_W-1:0];
		p.pl = pl[bilg_pkg::DIST_W-1:0]; p.pr = pr[bilg_pkg::DIST_W-1:0];
		p.tt = tt[bilg_pkg::DIST_W-1:0]; p.tb = tb[bilg_pkg::DIST_W-1:0];
		p.tl = tl[bilg_pkg::DIST_W-1:0]; p.tr = tr[bilg_pkg::DIST_W-1:0];
		p.last = last;
		return p;
	endfunction

	function automatic logic signed [bilg_pkg::DIST_W-1:0] rand_dist(bit positive);
		int sel;
		int unsigned u;
		logic [bilg_pkg::DIST_W-1:0] v;
		sel = $urandom_range(0, 9);
		if (sel == 0) u = $urandom;
		else if (sel < 3) u = $urandom_range(1, 16);
		else u = $urandom_range(1, 1 << $urandom_range(1, 22));
		v = u[bilg_pkg::DIST_W-1:0];
		if (!positive && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	task automatic test_directed();
		localparam int MX = 8388607;
		localparam int MN = -8388608;
		write_scale(bilg_pkg::SCALE_RESET);
		send_pixel(mk(256, 256, 256, 256, 256, 256, 256, 256, 0));   // perfect overlap
		send_pixel(mk(MX, MX, MX, MX, MX, MX, MX, MX, 0));
		send_pixel(mk(MN, MN, MN, MN, 1, 1, 1, 1, 0));                // pred clamped
		send_pixel(mk(1, 1, 1, 1, MX, MX, MX, MX, 0));                // IoU floor
		send_pixel(mk(MX, MX, MX, MX, 1, 1, 1, 1, 0));
		send_pixel(mk(0, -5, 0, -1, 300, 20, 7, 900, 0));
		send_pixel(mk(100, 900, 40, 3000, 500, 200, 70, 60, 0));      // mixed c flags
		send_pixel(mk(10, 10, 10, 10, 0, 10, 10, 10, 0));             // skipped, not counted
		send_pixel(mk(10, 10, 10, 10, 5, -100, -3, -4, 0));           // counted, skipped
		send_pixel(mk(10, 10, 10, 10, 5, 5, -3, 4, 0));               // counted, skipped
		send_pixel(mk(10, 10, 10, 10, -5, -6, -3, -4, 0));            // not counted
		send_pixel(mk(MN, MX, MN, MX, MN, MN, MN, MN, 1));            // last, skipped
		send_pixel(mk(1, 2, 3, 4, -1, -1, -1, -1, 1));                // empty batch
		send_pixel(mk(700, 20, 20, 700, 20, 700, 700, 20, 1));        // last with own loss
		drain_results();
		write_scale('0);
		send_pixel(mk(50, 60, 70, 80, 90, 10, 20, 30, 0));
		send_pixel(mk(MX, 1, MX, 1, 1, MX, 1, MX, 1));
		drain_results();
		write_scale(24'hFFFFFF);
		send_pixel(mk(1, 1, 1, 1, MX, MX, MX, MX, 0));                // gradient saturation
		send_pixel(mk(MX, MX, MX, MX, 1, 1, 1, 1, 0));
		send_pixel(mk(3, 900, 2, 5, 800, 4, 6, 1, 1));
		drain_results();
	endtask

	task automatic test_random(int n, logic [bilg_pkg::SCALE_W-1:0] scale, bit burst);
		pixel_t p;
		bit good;
		write_scale(scale);
		no_idle = burst;
		for (int i = 0; i < n; i++) begin
			good = $urandom_range(0, 9) < 8;
			p.pt = rand_dist(0); p.pb = rand_dist(0);
			p.pl = rand_dist(0); p.pr = rand_dist(0);
			p.tt = rand_dist(good); p.tb = rand_dist(good);
			p.tl = rand_dist(good); p.tr = rand_dist(good);
			if (!good && $urandom_range(0, 3) == 0) p.tb = 0;
			p.last = $urandom_range(0, 19) == 0;
			send_pixel(p);
		end
		no_idle = 1'b0;
		drain_results();
	endtask

	// result side: random back-pressure, checking, and the watchdog
	int stall_left = 0;
	int idle_cycles = 0;
	always @(posedge clk) begin
		result_t e;
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (out_ch.valid && out_ch.ready) begin
			if (expected_q.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result beat");
			end else begin
				e = expected_q.pop_front();
				if (out_ch.grad_top !== e.gt || out_ch.grad_bottom !== e.gb ||
						out_ch.grad_left !== e.gl || out_ch.grad_right !== e.gr ||
						out_ch.pixel_loss !== e.loss || out_ch.pixel_valid !== e.pvalid ||
						out_ch.mean_loss !== e.mean || out_ch.positive_total !== e.total ||
						out_ch.batch_done !== e.done) begin
					fails++;
					if (fails <= 10) begin
						$display("mismatch exp g=%h %h %h %h l=%h v=%b m=%h n=%h d=%b",
							e.gt, e.gb, e.gl, e.gr, e.loss, e.pvalid, e.mean, e.total,
							e.done);
						$display("         got g=%h %h %h %h l=%h v=%b m=%h n=%h d=%b",
							out_ch.grad_top, out_ch.grad_bottom, out_ch.grad_left,
							out_ch.grad_right, out_ch.pixel_loss, out_ch.pixel_valid,
							out_ch.mean_loss, out_ch.positive_total, out_ch.batch_done);
					end
				end
			end
		end
		if (!arst_n || no_idle) begin
			out_ch.ready <= arst_n;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if ($urandom_range(0, 99) < 15)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(50, 1500)
					: $urandom_range(1, 4);
		end
	end

	initial begin
		int unsigned rs;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, bilg_pkg::SCALE_RESET, 0);
		rs = $urandom;
		test_random(150, rs[bilg_pkg::SCALE_W-1:0], 0);
		test_random(100, 24'hFFFFFF, 1);
		test_random(100, '0, 0);
		rs = $urandom_range(1, 4096);
		test_random(200, rs[bilg_pkg::SCALE_W-1:0], 0);
		repeat (200) @(posedge clk);
		if (fails == 0 && expected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
